>>> rtl/core/triangle_unit_normal_defines.svh
// Assertion macros shared by the triangle unit normal RTL.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define TUN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tun assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define TUN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tun assertion failed");

`endif

>>> rtl/core/tun_pkg.sv
package tun_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int EDGE_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int MAG_W  = PROD_W + 1;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = MAG_W + 1;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int DIV_W  = ROOT_W + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
    } norm_out_t;

    // Cross product in sign/magnitude form plus its squared length and degenerate flag.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [SUM_W-1:0]      sum;
        logic                  degenerate;
    } cross_t;

endpackage

>>> rtl/core/tun_front.sv
module tun_front
    import tun_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tri_in_t   in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output cross_t    push_data
);

    logic adv;

    logic [5:0] v_reg;
    logic [5:0] v_next;

    logic signed [2:0][EDGE_W-1:0] e1_reg, e1_next, e2_reg, e2_next;
    logic signed [2:0][PROD_W-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [2:0][MAG_W-1:0]         mag3_reg, mag3_next, mag4_reg, mag5_reg;
    logic [2:0]                    neg3_reg, neg3_next, neg4_reg, neg5_reg;
    logic [2:0][2*HALF_W-1:0]      hh_reg, hh_next, hl_reg, hl_next, ll_reg, ll_next;
    logic [2:0][SQ_W-1:0]          sq_reg, sq_next;
    cross_t                        out_reg, out_next;

    assign adv        = !v_reg[5] || push_ready;
    assign in_ready   = adv;
    assign push_valid = v_reg[5];
    assign push_data  = out_reg;
    assign v_next     = {v_reg[4:0], in_valid};

    always_comb
    begin
        logic signed [MAG_W-1:0] cr;
        logic [HALF_W-1:0]       lo, hi;
        e1_next[0] = EDGE_W'(in_data.vertex_b_x) - EDGE_W'(in_data.vertex_a_x);
        e1_next[1] = EDGE_W'(in_data.vertex_b_y) - EDGE_W'(in_data.vertex_a_y);
        e1_next[2] = EDGE_W'(in_data.vertex_b_z) - EDGE_W'(in_data.vertex_a_z);
        e2_next[0] = EDGE_W'(in_data.vertex_c_x) - EDGE_W'(in_data.vertex_a_x);
        e2_next[1] = EDGE_W'(in_data.vertex_c_y) - EDGE_W'(in_data.vertex_a_y);
        e2_next[2] = EDGE_W'(in_data.vertex_c_z) - EDGE_W'(in_data.vertex_a_z);

        pa_next[0] = $signed(e1_reg[1]) * $signed(e2_reg[2]);
        pb_next[0] = $signed(e1_reg[2]) * $signed(e2_reg[1]);
        pa_next[1] = $signed(e1_reg[2]) * $signed(e2_reg[0]);
        pb_next[1] = $signed(e1_reg[0]) * $signed(e2_reg[2]);
        pa_next[2] = $signed(e1_reg[0]) * $signed(e2_reg[1]);
        pb_next[2] = $signed(e1_reg[1]) * $signed(e2_reg[0]);

        for (int i = 0; i < 3; i++)
        begin
            cr = $signed({pa_reg[i][PROD_W-1], pa_reg[i]})
               - $signed({pb_reg[i][PROD_W-1], pb_reg[i]});
            neg3_next[i] = cr[MAG_W-1];
            mag3_next[i] = cr[MAG_W-1] ? MAG_W'(-cr) : MAG_W'(cr);

            // Square split into half-width products.
            lo = mag3_reg[i][HALF_W-1:0];
            hi = HALF_W'(mag3_reg[i] >> HALF_W);
            hh_next[i] = hi * hi;
            hl_next[i] = hi * lo;
            ll_next[i] = lo * lo;

            sq_next[i] = (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                       + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                       + SQ_W'(ll_reg[i]);
        end

        out_next.mag        = mag5_reg;
        out_next.neg        = neg5_reg;
        out_next.sum        = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        out_next.degenerate = (mag5_reg[0] == '0) && (mag5_reg[1] == '0)
                           && (mag5_reg[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            sq_reg   <= sq_next;
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
            out_reg  <= out_next;
        end
    end

endmodule

>>> rtl/core/tun_fifo.sv
module tun_fifo
    import tun_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  cross_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output cross_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cross_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`include "triangle_unit_normal_defines.svh"

    `TUN_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `TUN_ASSERT_NEXT(a_pop_drains, pop && !push, count_reg + 1'b1 == $past(count_reg))

endmodule

>>> rtl/core/tun_back.sv
module tun_back
    import tun_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cross_t    pop_data,
    output logic      out_valid,
    input  logic      out_ready,
    output norm_out_t out_data
);

    typedef struct packed {
        logic [SUM_W-1:0]      rad;
        logic [ROOT_W-1:0]     root;
        logic [REM_W-1:0]      rem;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degenerate;
    } sq_stage_t;

    typedef struct packed {
        logic [2:0][DIV_W-1:0]        rem;
        logic [2:0][NORMAL_WIDTH-1:0] quo;
        logic [ROOT_W-1:0]            root;
        logic [2:0]                   neg;
        logic                         degenerate;
    } dv_stage_t;

    logic adv;

    sq_stage_t sq_reg [ROOT_W];
    sq_stage_t sq_next [ROOT_W];
    logic [ROOT_W-1:0] sv_reg, sv_next;

    dv_stage_t dv_reg [NORMAL_WIDTH];
    dv_stage_t dv_next [NORMAL_WIDTH];
    logic [NORMAL_WIDTH-1:0] dvv_reg, dvv_next;

    norm_out_t out_reg, out_next;
    logic      out_valid_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign sv_next   = {sv_reg[ROOT_W-2:0], pop_valid};
    assign dvv_next  = {dvv_reg[NORMAL_WIDTH-2:0], sv_reg[ROOT_W-1]};

    // Square root, one result bit per stage.
    always_comb
    begin
        sq_stage_t        src;
        logic [REM_W-1:0] rem_sh, trial;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                src.rad        = pop_data.sum;
                src.root       = '0;
                src.rem        = '0;
                src.mag        = pop_data.mag;
                src.neg        = pop_data.neg;
                src.degenerate = pop_data.degenerate;
            end
            else
            begin
                src = sq_reg[k-1];
            end
            rem_sh = {src.rem[REM_W-3:0], src.rad[SUM_W-1 -: 2]};
            trial  = {1'b0, src.root, 2'b01};
            sq_next[k] = src;
            sq_next[k].rad = src.rad << 2;
            if (rem_sh >= trial)
            begin
                sq_next[k].rem  = rem_sh - trial;
                sq_next[k].root = {src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rem_sh;
                sq_next[k].root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Restoring division of each magnitude by the length, one quotient bit per stage.
    always_comb
    begin
        dv_stage_t        src;
        logic [DIV_W-1:0] rr;
        for (int j = 0; j < NORMAL_WIDTH; j++)
        begin
            if (j == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    src.rem[i] = DIV_W'(sq_reg[ROOT_W-1].mag[i]);
                end
                src.quo        = '0;
                src.root       = sq_reg[ROOT_W-1].root;
                src.neg        = sq_reg[ROOT_W-1].neg;
                src.degenerate = sq_reg[ROOT_W-1].degenerate;
            end
            else
            begin
                src = dv_reg[j-1];
            end
            dv_next[j] = src;
            for (int i = 0; i < 3; i++)
            begin
                rr = (j == 0) ? src.rem[i] : {src.rem[i][DIV_W-2:0], 1'b0};
                if (rr >= {1'b0, src.root})
                begin
                    dv_next[j].rem[i] = rr - {1'b0, src.root};
                    dv_next[j].quo[i] = {src.quo[i][NORMAL_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    dv_next[j].rem[i] = rr;
                    dv_next[j].quo[i] = {src.quo[i][NORMAL_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate +1.0, apply the sign and zero the normal of a degenerate triangle.
    always_comb
    begin
        logic [2:0][NORMAL_WIDTH-1:0] res;
        logic [NORMAL_WIDTH-1:0]      q;
        for (int i = 0; i < 3; i++)
        begin
            q = dv_reg[NORMAL_WIDTH-1].quo[i];
            if (!dv_reg[NORMAL_WIDTH-1].neg[i] && q[NORMAL_WIDTH-1])
            begin
                q = {1'b0, {(NORMAL_WIDTH-1){1'b1}}};
            end
            res[i] = dv_reg[NORMAL_WIDTH-1].neg[i] ? -q : q;
            if (dv_reg[NORMAL_WIDTH-1].degenerate)
            begin
                res[i] = '0;
            end
        end
        out_next.normal_x   = res[0];
        out_next.normal_y   = res[1];
        out_next.normal_z   = res[2];
        out_next.degenerate = dv_reg[NORMAL_WIDTH-1].degenerate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg        <= '0;
            dvv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg        <= sv_next;
            dvv_reg       <= dvv_next;
            out_valid_reg <= dvv_reg[NORMAL_WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int j = 0; j < NORMAL_WIDTH; j++)
            begin
                dv_reg[j] <= dv_next[j];
            end
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/core/triangle_unit_normal.sv
// Channel   Direction   Handshake            Payload
// in        input       in_valid/in_ready    in_data   (tri_in_t, three Q12.12 vertices)
// out       output      out_valid/out_ready  out_data  (norm_out_t, Q1.15 normal and flag)
//
// One transaction is accepted per clock while the output side keeps taking results.
// The path runs through the front registers, the queue, 52 square root
// stages, 16 division stages and one output register at the default widths.
// The square root and the division each resolve one bit per pipeline stage.
// Reset clears only valid bits, queue pointers and count; datapath registers are not reset.
// A stall on out_ready freezes the back pipeline; the queue then fills and the front
// pipeline freezes in turn, which drops in_ready.
module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tri_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output norm_out_t out_data
);

    // Front to queue transaction.
    logic   f_valid;
    logic   f_ready;
    cross_t f_data;

    // Queue to back transaction.
    logic   b_valid;
    logic   b_ready;
    cross_t b_data;

    // The front forms edges, the cross product in sign/magnitude form and the
    // exact squared length, and flags a zero cross product as degenerate.
    tun_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data)
    );

    // A short queue lets the front keep accepting while the back is stalled.
    tun_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    // The back takes the integer square root of the squared length, divides each
    // scaled component by it, saturates and signs the result and zeroes it when degenerate.
    tun_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_data  (b_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`include "triangle_unit_normal_defines.svh"

    // A degenerate triangle must come out as an all-zero normal.
    `TUN_ASSERT_NOW(a_degenerate_zero, out_valid && out_data.degenerate, (out_data.normal_x == '0) && (out_data.normal_y == '0) && (out_data.normal_z == '0))

endmodule

>>> sim/triangle_unit_normal_tb.sv
`timescale 1ns / 100ps

module triangle_unit_normal_tb;
    import tun_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_COUNT   = 2000;
    localparam int HOLD_OFF_LEN   = 600;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    tri_in_t   in_data;
    logic      out_valid;
    logic      out_ready;
    norm_out_t out_data;

    // Computes the Q1.15 unit normal that the block should produce for one triangle.
    function automatic norm_out_t unit_normal_of(tri_in_t t);
        longint        e1x, e1y, e1z, e2x, e2y, e2z;
        longint        cr [3];
        bit [127:0]    mag [3];
        bit [127:0]    sum_sq;
        bit [127:0]    root;
        bit [127:0]    cand;
        bit [127:0]    quo;
        logic [NORMAL_WIDTH-1:0] comp [3];
        norm_out_t     r;
        e1x = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
        e1y = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
        e1z = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
        e2x = longint'(t.vertex_c_x) - longint'(t.vertex_a_x);
        e2y = longint'(t.vertex_c_y) - longint'(t.vertex_a_y);
        e2z = longint'(t.vertex_c_z) - longint'(t.vertex_a_z);
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        sum_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
            sum_sq += mag[i] * mag[i];
        end
        r = '0;
        if (sum_sq == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        // Integer square root, one bit at a time from the top.
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum_sq)
                root = cand;
        end
        for (int i = 0; i < 3; i++)
        begin
            quo = (mag[i] << (NORMAL_WIDTH - 1)) / root;
            // Only a positive +1.0 needs clamping; -1.0 is representable.
            if (cr[i] >= 0 && quo > (128'd1 << (NORMAL_WIDTH - 1)) - 1)
                quo = (128'd1 << (NORMAL_WIDTH - 1)) - 1;
            comp[i] = (cr[i] < 0) ? -quo[NORMAL_WIDTH-1:0] : quo[NORMAL_WIDTH-1:0];
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    // Holds the normals still owed by the block, oldest first.
    class normal_scoreboard;
        norm_out_t owed_normals[$];
        int        error_count;

        function new();
            error_count = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        function void note_triangle(tri_in_t t);
            owed_normals.push_back(unit_normal_of(t));
        endfunction

        task check_normal(norm_out_t got);
            norm_out_t want;
            if (owed_normals.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = owed_normals.pop_front();
            if (got.normal_x !== want.normal_x)
                report($sformatf("normal_x got %0d want %0d", got.normal_x, want.normal_x));
            if (got.normal_y !== want.normal_y)
                report($sformatf("normal_y got %0d want %0d", got.normal_y, want.normal_y));
            if (got.normal_z !== want.normal_z)
                report($sformatf("normal_z got %0d want %0d", got.normal_z, want.normal_z));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate got %b want %b", got.degenerate,
                                 want.degenerate));
        endtask
    endclass

    normal_scoreboard sb;
    int  idle_cycles;
    int  results_seen;
    bit  hold_off_done;

    triangle_unit_normal DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are sampled at the clock edge, before any nonblocking update lands,
    // so every check sees the values that the block saw at that edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_triangle(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_normal(out_data);
            results_seen++;
        end
    end

    // The watchdog ends the run when no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results owed", sb.owed_normals.size());
            $display("FAIL triangle_unit_normal");
            $finish;
        end
    end

    function automatic tri_in_t make_triangle(int ax, int ay, int az, int bx, int by,
                                              int bz, int cx, int cy, int cz);
        tri_in_t t;
        t.vertex_a_x = COORD_WIDTH'(ax);
        t.vertex_a_y = COORD_WIDTH'(ay);
        t.vertex_a_z = COORD_WIDTH'(az);
        t.vertex_b_x = COORD_WIDTH'(bx);
        t.vertex_b_y = COORD_WIDTH'(by);
        t.vertex_b_z = COORD_WIDTH'(bz);
        t.vertex_c_x = COORD_WIDTH'(cx);
        t.vertex_c_y = COORD_WIDTH'(cy);
        t.vertex_c_z = COORD_WIDTH'(cz);
        return t;
    endfunction

    // Random triangles of several kinds: any bit pattern, small nearby triangles,
    // collinear (degenerate) ones and triangles parallel to a coordinate plane.
    function automatic tri_in_t random_triangle();
        tri_in_t          t;
        logic [7*32-1:0]  raw;
        int               ax, ay, az, dx, dy, dz, k;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(tri_in_t)-1:0];
        ax = $signed($urandom_range(0, 2097151)) - 1048576;
        ay = $signed($urandom_range(0, 2097151)) - 1048576;
        az = $signed($urandom_range(0, 2097151)) - 1048576;
        dx = $signed($urandom_range(0, 4000)) - 2000;
        dy = $signed($urandom_range(0, 4000)) - 2000;
        dz = $signed($urandom_range(0, 4000)) - 2000;
        k  = $signed($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5: t = make_triangle(ax, ay, az, ax + dx, ay + dy, az + dz,
                                    ax + dy, ay - dz, az + dx + 7);
            6: t = make_triangle(ax, ay, az, ax + dx, ay + dy, az + dz,
                                 ax + k * dx, ay + k * dy, az + k * dz);
            7: t = make_triangle(ax, ay, az, ax + dx, ay + dy, az, ax + dz, ay - dx, az);
            8: t = make_triangle(ax, ay, az, ax, ay + dy, az + dz, ax, ay + dx, az - dy);
            default: t = make_triangle(ax, ay, az, ax + dx, ay, az + dz, ax - dz, ay, az);
        endcase
        return t;
    endfunction

    // Offers one triangle and holds it until the block takes it.
    task send_triangle(tri_in_t t);
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // The receiver alternates between always, mostly and half ready and mostly stalled.
    // Once, well into the run, it holds off long enough for the queue and the front
    // pipeline to fill so that in_ready must drop.
    initial
    begin
        int phase_len;
        int ready_pct;
        @(posedge rst_n);
        forever
        begin
            if (!hold_off_done && results_seen > 300)
            begin
                hold_off_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            phase_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                default: ready_pct = 20;
            endcase
            repeat (phase_len)
            begin
                out_ready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        tri_in_t directed[$];
        int      burst_left;
        sb            = new();
        idle_cycles   = 0;
        results_seen  = 0;
        hold_off_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All vertices at one point gives the degenerate flag.
        directed.push_back(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_triangle(8388607, 8388607, 8388607, 8388607, 8388607,
                                         8388607, 8388607, 8388607, 8388607));
        directed.push_back(make_triangle(-8388608, -8388608, -8388608, -8388608,
                                         -8388608, -8388608, -8388608, -8388608, -8388608));
        // Collinear vertices are degenerate too.
        directed.push_back(make_triangle(100, 200, 300, 200, 400, 600, -300, -600, -900));
        directed.push_back(make_triangle(5, 6, 7, 5, 6, 7, 9, -3, 1));
        // A normal along one axis hits the saturation at +1; reversed winding gives -1.
        directed.push_back(make_triangle(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        directed.push_back(make_triangle(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
        directed.push_back(make_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_triangle(0, 0, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
        directed.push_back(make_triangle(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // Largest edges the coordinates allow.
        directed.push_back(make_triangle(-8388608, -8388608, -8388608, 8388607, -8388608,
                                         -8388608, -8388608, 8388607, -8388608));
        directed.push_back(make_triangle(-8388608, -8388608, -8388608, 8388607, 8388607,
                                         -8388608, -8388608, 8388607, 8388607));
        directed.push_back(make_triangle(8388607, -8388608, 8388607, -8388608, 8388607,
                                         -8388608, 8388607, 8388607, -8388608));
        directed.push_back(make_triangle(-8388608, 8388607, 0, 8388607, -8388608, 1,
                                         0, 0, -8388608));
        // Tiny edges and an equal-component normal.
        directed.push_back(make_triangle(1, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_triangle(-1, 0, 0, 0, -1, 0, 0, 0, -1));
        directed.push_back(make_triangle(12345, -678, 4096, 12346, -678, 4096,
                                         12345, -677, 4097));

        foreach (directed[i])
            send_triangle(directed[i]);

        // Random triangles in bursts, most of them separated by random gaps.
        burst_left = 0;
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 60);
                if ($urandom_range(0, 2) != 0)
                    idle_input($urandom_range(1, 12));
            end
            send_triangle(random_triangle());
            burst_left--;
        end
        in_valid <= 1'b0;

        while (sb.owed_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0)
            $display("PASS triangle_unit_normal");
        else
            $display("FAIL triangle_unit_normal");
        $finish;
    end

endmodule
